### rtl/bme_pkg.sv
// Shared constants for the byte modular exponentiation block.
package bme_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_W  = 16;

    localparam logic [CFG_W-1:0] EXPONENT_RESET = 16'd147;
    localparam logic [CFG_W-1:0] MODULUS_RESET  = 16'd1;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_EXPONENT = 1'b0,
        REG_MODULUS  = 1'b1
    } reg_idx_t;

    // operation started on the shared modular multiplier
    typedef enum logic [1:0] {
        OP_REDUCE = 2'd0,
        OP_MUL    = 2'd1,
        OP_SQR    = 2'd2
    } mm_op_t;

    // handshake between the sequencer and the multiplier
    typedef struct packed {
        logic start;
    } mm_req_t;

    typedef struct packed {
        logic done;
        logic busy;
    } mm_rsp_t;

endpackage

### rtl/bme_mulmod.sv
// Bit-serial interleaved modular multiplier: (a * b) mod m, one bit of a per cycle.
module bme_mulmod #(
    parameter int unsigned MOD_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bme_pkg::mm_req_t     req,
    input  logic [MOD_BITS-1:0]  a,
    input  logic [MOD_BITS-1:0]  b,
    input  logic [MOD_BITS-1:0]  m,
    output bme_pkg::mm_rsp_t     rsp,
    output logic [MOD_BITS-1:0]  result
);

    localparam int unsigned CNT_W = $clog2(MOD_BITS);
    localparam int unsigned W     = MOD_BITS + 1;

    logic [MOD_BITS-1:0] a_reg;
    logic [MOD_BITS-1:0] b_reg;
    logic [MOD_BITS-1:0] m_reg;
    logic [MOD_BITS-1:0] acc_reg;
    logic [MOD_BITS-1:0] acc_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [W-1:0] dbl;
    logic [W-1:0] dbl_red;
    logic [W-1:0] sum;
    logic [W-1:0] sum_red;
    logic [W-1:0] m_ext;

    // acc stays below m: 2*acc < 2m needs one subtract, adding b < m needs another
    always_comb
    begin
        m_ext   = {1'b0, m_reg};
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        sum     = dbl_red + (a_reg[MOD_BITS-1] ? {1'b0, b_reg} : {W{1'b0}});
        sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
        acc_next = sum_red[MOD_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MOD_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            m_reg   <= m;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            a_reg   <= {a_reg[MOD_BITS-2:0], 1'b0};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign result   = acc_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("multiplier done without a running operation");

    a_acc_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && m_reg != '0 && !$past(req.start)) |-> (acc_reg < m_reg))
        else $error("multiplier accumulator not reduced");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("multiplier did not start");

endmodule

### rtl/byte_modular_exponentiation.sv
// Byte modular exponentiation: c^exponent mod modulus by square-and-multiply on a serial multiplier.
// Every modular multiply runs on the one shared bit-serial multiplier.
// Per byte: one base reduction, then EXP_BITS squarings plus one multiply per set exponent bit;
// a zero exponent or modulus skips the multiplier. The result is registered in S_FINISH, which
// waits while an earlier result is not yet taken, and s_tready returns with S_IDLE.
// One byte is in work at a time. Async active-low reset: exponent = 147, modulus = 1, no item held.
module byte_modular_exponentiation #(
    parameter int unsigned EXP_BITS = 16,
    parameter int unsigned MOD_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bme_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] cipher_byte
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bme_pkg::BYTE_W-1:0]  m_tdata,   // [7:0] plain_byte
    output logic                        m_tlast,
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic [bme_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int unsigned BW    = bme_pkg::BYTE_W;
    localparam int unsigned CW    = bme_pkg::CFG_W;
    localparam int unsigned BCW   = $clog2(EXP_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_MUL,
        S_SQR,
        S_FINISH
    } state_t;

    state_t               state_reg;
    logic [CW-1:0]        exponent_reg;
    logic [CW-1:0]        modulus_reg;
    logic [BW-1:0]        cipher_reg;
    logic                 last_reg;
    logic [EXP_BITS-1:0]  exp_sh_reg;
    logic [BCW-1:0]       bit_cnt_reg;
    logic [MOD_BITS-1:0]  mod_reg;
    logic [MOD_BITS-1:0]  r_reg;
    logic [MOD_BITS-1:0]  base_reg;
    bme_pkg::mm_op_t      op_reg;
    logic                 start_reg;
    logic                 m_tvalid_reg;
    logic [BW-1:0]        m_tdata_reg;
    logic                 m_tlast_reg;

    logic [EXP_BITS+CW-1:0] exp_wide;
    logic [MOD_BITS+CW-1:0] mod_wide;
    logic [EXP_BITS-1:0]    exp_eff;
    logic [MOD_BITS-1:0]    mod_eff;
    logic [MOD_BITS-1:0]    mm_a;
    logic [MOD_BITS-1:0]    mm_b;
    logic [MOD_BITS-1:0]    mm_result;
    bme_pkg::mm_req_t       mm_req;
    bme_pkg::mm_rsp_t       mm_rsp;
    logic                   s_xfer;

    // exponent and modulus widths fitted to the datapath
    always_comb
    begin
        exp_wide = {{EXP_BITS{1'b0}}, exponent_reg};
        mod_wide = {{MOD_BITS{1'b0}}, modulus_reg};
        exp_eff  = exp_wide[EXP_BITS-1:0];
        mod_eff  = mod_wide[MOD_BITS-1:0];
    end

    // operand select; the base reduction multiplies c by 1 mod m (by 0 when m is 1)
    always_comb
    begin
        case (op_reg)
            bme_pkg::OP_REDUCE:
            begin
                mm_a = MOD_BITS'(cipher_reg);
                mm_b = (mod_reg == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
            end
            bme_pkg::OP_MUL:
            begin
                mm_a = r_reg;
                mm_b = base_reg;
            end
            default:
            begin
                mm_a = base_reg;
                mm_b = base_reg;
            end
        endcase
    end

    assign mm_req.start = start_reg;

    bme_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mm_req),
        .a      (mm_a),
        .b      (mm_b),
        .m      (mod_reg),
        .rsp    (mm_rsp),
        .result (mm_result)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= bme_pkg::EXPONENT_RESET;
            modulus_reg  <= bme_pkg::MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bme_pkg::REG_EXPONENT: exponent_reg <= cfg_wdata;
                bme_pkg::REG_MODULUS:  modulus_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            start_reg    <= 1'b0;
            op_reg       <= bme_pkg::OP_REDUCE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            // S_FINISH drives m_tvalid_reg itself
            if (m_tvalid_reg && m_tready && state_reg != S_FINISH)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_xfer)
                    begin
                        if (exp_eff == '0)
                            state_reg <= S_FINISH;
                        else if (mod_eff == '0)
                            state_reg <= S_FINISH;
                        else
                        begin
                            state_reg <= S_RED;
                            op_reg    <= bme_pkg::OP_REDUCE;
                            start_reg <= 1'b1;
                        end
                    end
                end
                S_RED:
                begin
                    if (mm_rsp.done)
                    begin
                        start_reg <= 1'b1;
                        if (exp_sh_reg[0])
                        begin
                            state_reg <= S_MUL;
                            op_reg    <= bme_pkg::OP_MUL;
                        end
                        else
                        begin
                            state_reg <= S_SQR;
                            op_reg    <= bme_pkg::OP_SQR;
                        end
                    end
                end
                S_MUL:
                begin
                    if (mm_rsp.done)
                    begin
                        state_reg <= S_SQR;
                        op_reg    <= bme_pkg::OP_SQR;
                        start_reg <= 1'b1;
                    end
                end
                S_SQR:
                begin
                    if (mm_rsp.done)
                    begin
                        if (bit_cnt_reg == BCW'(1))
                            state_reg <= S_FINISH;
                        else
                        begin
                            start_reg <= 1'b1;
                            if (exp_sh_reg[1])
                            begin
                                state_reg <= S_MUL;
                                op_reg    <= bme_pkg::OP_MUL;
                            end
                            else
                            begin
                                state_reg <= S_SQR;
                                op_reg    <= bme_pkg::OP_SQR;
                            end
                        end
                    end
                end
                S_FINISH:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (s_xfer)
                begin
                    cipher_reg  <= s_tdata;
                    last_reg    <= s_tlast;
                    exp_sh_reg  <= exp_eff;
                    bit_cnt_reg <= BCW'(EXP_BITS);
                    mod_reg     <= mod_eff;
                    // zero exponent gives 1; zero modulus gives 0
                    r_reg       <= (exp_eff == '0 || mod_eff != '0) ? MOD_BITS'(1) : '0;
                end
            end
            S_RED:
            begin
                if (mm_rsp.done)
                    base_reg <= mm_result;
            end
            S_MUL:
            begin
                if (mm_rsp.done)
                    r_reg <= mm_result;
            end
            S_SQR:
            begin
                if (mm_rsp.done)
                begin
                    base_reg    <= mm_result;
                    exp_sh_reg  <= exp_sh_reg >> 1;
                    bit_cnt_reg <= bit_cnt_reg - 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_reg <= r_reg[BW-1:0];
                    m_tlast_reg <= last_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer |=> !s_tready)
        else $error("input taken while a byte is in work");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mm_rsp.done |-> (state_reg == S_RED || state_reg == S_MUL || state_reg == S_SQR))
        else $error("multiplier result arrived outside a wait state");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result presented without finishing a byte");

    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> !mm_rsp.busy)
        else $error("multiplier started while busy");

endmodule

### bench/tb.sv
// Self-checking testbench for the byte modular exponentiation stream block.
`timescale 1ns / 1ps

module tb;

    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 96;
    localparam int HOLD_CYCLES    = 2000;
    // slowest byte: one reduction, 16 squarings and 16 multiplies
    localparam int LATENCY_MARGIN = 640;
    localparam int QUIET_LIMIT    = 20000;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } plain_t;

    class plain_scoreboard;
        logic [bme_pkg::CFG_W-1:0] exp_reg = bme_pkg::EXPONENT_RESET;
        logic [bme_pkg::CFG_W-1:0] mod_reg = bme_pkg::MODULUS_RESET;
        plain_t plain_due[$];
        int     ciphers_seen = 0;
        int     plains_checked = 0;
        int     mismatches = 0;

        // square-and-multiply, reducing after each product
        function automatic logic [7:0] pow_mod_byte(logic [7:0] c);
            logic [63:0] acc;
            logic [63:0] base_sq;
            int i;
            if (exp_reg == '0)
                return 8'd1;
            if (mod_reg == '0)
                return 8'd0;
            base_sq = 64'(c) % 64'(mod_reg);
            acc = 64'd1;
            for (i = 0; i < bme_pkg::CFG_W; i++)
            begin
                if (exp_reg[i])
                    acc = (acc * base_sq) % 64'(mod_reg);
                base_sq = (base_sq * base_sq) % 64'(mod_reg);
            end
            return acc[7:0];
        endfunction

        function void note_cipher(logic [7:0] c, logic last);
            plain_t p;
            p.data = pow_mod_byte(c);
            p.last = last;
            plain_due.push_back(p);
            ciphers_seen++;
        endfunction

        function void check_plain(logic [7:0] data, logic last);
            plain_t p;
            plains_checked++;
            if (plain_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %02h last %0b",
                         $time, data, last);
                mismatches++;
                return;
            end
            p = plain_due.pop_front();
            if (data !== p.data)
            begin
                $display("%0t: plain_byte mismatch, expected %02h, actual %02h",
                         $time, p.data, data);
                mismatches++;
            end
            if (last !== p.last)
            begin
                $display("%0t: last_out mismatch, expected %0b, actual %0b",
                         $time, p.last, last);
                mismatches++;
            end
        endfunction

        function int pending();
            return plain_due.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [bme_pkg::BYTE_W-1:0] s_tdata;   // [7:0] cipher_byte
    logic                       s_tlast;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [bme_pkg::BYTE_W-1:0] m_tdata;   // [7:0] plain_byte
    logic                       m_tlast;
    logic                       cfg_we;
    logic                       cfg_addr;
    logic [bme_pkg::CFG_W-1:0]  cfg_wdata;

    plain_scoreboard sb = new();
    int tx_idle_pct = 35;
    int rx_idle_pct = 54;
    bit hold_request = 1'b0;
    int quiet_cycles = 0;
    int keys_loaded = 0;

    byte_modular_exponentiation u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // transfer monitor and stall watchdog
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sb.note_cipher(s_tdata, s_tlast);
        if (m_tvalid && m_tready)
            sb.check_plain(m_tdata, m_tlast);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random backpressure, plus one long hold-off on request
    initial
    begin : rx_side
        int k;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_cipher(input logic [7:0] c, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain_plain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic load_key(input logic [bme_pkg::CFG_W-1:0] e,
                            input logic [bme_pkg::CFG_W-1:0] m);
        cfg_we    <= 1'b1;
        cfg_addr  <= bme_pkg::REG_EXPONENT;
        cfg_wdata <= e;
        @(posedge clk);
        cfg_addr  <= bme_pkg::REG_MODULUS;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.exp_reg = e;
        sb.mod_reg = m;
        keys_loaded++;
    endtask

    initial
    begin : stimulus
        int p;
        int n;
        int j;
        int len;
        logic [bme_pkg::CFG_W-1:0] e;
        logic [bme_pkg::CFG_W-1:0] m;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= bme_pkg::REG_EXPONENT;
        cfg_wdata <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key: exponent 147 with modulus one gives zero
        send_cipher(8'h00, 1'b0);
        send_cipher(8'hff, 1'b1);
        drain_plain();
        // zero exponent gives one, also for 0^0 and modulus one
        load_key(16'd0, 16'd1);
        send_cipher(8'h00, 1'b0);
        send_cipher(8'hff, 1'b1);
        drain_plain();
        load_key(16'd0, 16'd0);
        send_cipher(8'h07, 1'b1);
        drain_plain();
        // zero modulus with nonzero exponent gives zero
        load_key(16'hffff, 16'd0);
        send_cipher(8'hc8, 1'b0);
        send_cipher(8'h00, 1'b1);
        drain_plain();
        // largest key: residues above 255 get truncated
        load_key(16'hffff, 16'hffff);
        send_cipher(8'hff, 1'b0);
        send_cipher(8'hfe, 1'b0);
        send_cipher(8'h02, 1'b0);
        send_cipher(8'h00, 1'b0);
        send_cipher(8'h01, 1'b1);
        drain_plain();
        load_key(16'd1, 16'hffff);
        send_cipher(8'h00, 1'b0);
        send_cipher(8'h01, 1'b0);
        send_cipher(8'h80, 1'b0);
        send_cipher(8'hff, 1'b1);
        drain_plain();
        load_key(16'd2, 16'd65521);
        send_cipher(8'hff, 1'b0);
        send_cipher(8'haa, 1'b0);
        send_cipher(8'h55, 1'b1);
        drain_plain();
        load_key(16'd3, 16'd256);
        send_cipher(8'h03, 1'b0);
        send_cipher(8'hf1, 1'b1);
        drain_plain();

        for (p = 0; p < PHASES; p++)
        begin
            case ($urandom_range(0, 9))
                0:       e = 16'd0;
                1:       e = 16'hffff;
                2:       e = 16'd1;
                default: e = 16'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 19))
                0:       m = 16'd0;
                1:       m = 16'd1;
                2, 3:    m = 16'hffff;
                4:       m = 16'd256;
                5:       m = 16'd257;
                6:       m = 16'($urandom_range(2, 255));
                default: m = 16'($urandom_range(2, 65535));
            endcase
            load_key(e, m);
            if (p == PHASES / 3)
            begin
                tx_idle_pct = 54;
                rx_idle_pct = 35;
            end
            else if (p == 2 * PHASES / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // long receiver hold-off so the block backs up into its input
            if (p == PHASES / 3 + 1)
                hold_request = 1'b1;
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                len = $urandom_range(1, 16);
                for (j = 0; j < len && n < PHASE_ITEMS; j++)
                begin
                    send_cipher(8'($urandom_range(0, 255)),
                                (j == len - 1) || (n == PHASE_ITEMS - 1));
                    n++;
                end
            end
            drain_plain();
        end

        repeat (LATENCY_MARGIN) @(posedge clk);
        $display("Sent %0d cipher bytes over %0d keys, checked %0d plain bytes",
                 sb.ciphers_seen, keys_loaded + 1, sb.plains_checked);
        $display("Covered zero exponent, zero and unit modulus, truncated residues, backpressure");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
